// ----- sv/acc_pkg.sv -----
// ----------------------------------------------------------------------------
// Affine character cipher package
// Shared widths, character codes, register indexes and the config struct.
// ----------------------------------------------------------------------------
`default_nettype none

package acc_pkg;

    // Field and datapath widths
    localparam int ACC_CHAR_W = 8;
    localparam int ACC_KEY_W  = 7;
    localparam int ACC_SUM_W  = 2 * ACC_KEY_W;
    localparam int ACC_PROD_W = ACC_SUM_W + ACC_KEY_W;
    localparam int ACC_IDX_W  = 2;

    // Default number of long-division steps per pipeline stage
    localparam int ACC_STEPS_DEF = 3;

    // Character codes
    localparam logic [ACC_CHAR_W-1:0] CH_NEWLINE  = 8'd10;
    localparam logic [ACC_CHAR_W-1:0] CH_SPACE    = 8'd32;
    localparam logic [ACC_CHAR_W-1:0] CH_UPPER_A  = 8'd65;
    localparam logic [ACC_CHAR_W-1:0] CH_UPPER_Z  = 8'd90;
    localparam logic [ACC_CHAR_W-1:0] CH_LOWER_A  = 8'd97;
    localparam logic [ACC_CHAR_W-1:0] CH_LOWER_Z  = 8'd122;
    localparam logic [ACC_CHAR_W-1:0] CH_CASE_GAP = 8'd32;

    // Register indexes
    localparam logic [ACC_IDX_W-1:0] CFG_MODULUS    = 2'd0;
    localparam logic [ACC_IDX_W-1:0] CFG_MULTIPLIER = 2'd1;
    localparam logic [ACC_IDX_W-1:0] CFG_OFFSET     = 2'd2;
    localparam logic [ACC_IDX_W-1:0] CFG_DECRYPT    = 2'd3;

    // Register reset values
    localparam logic [ACC_KEY_W-1:0] RST_MODULUS    = 7'd27;
    localparam logic [ACC_KEY_W-1:0] RST_MULTIPLIER = 7'd1;
    localparam logic [ACC_KEY_W-1:0] RST_OFFSET     = 7'd0;

    // Live configuration; m is the effective modulus (never zero)
    typedef struct packed {
        logic [ACC_KEY_W-1:0] m;
        logic [ACC_KEY_W-1:0] mult;
        logic [ACC_KEY_W-1:0] offset;
        logic                 decrypt;
    } t_cfg;

endpackage

`default_nettype wire

// ----- sv/acc_in_if.sv -----
// ----------------------------------------------------------------------------
// Input character channel
// Valid/ready channel carrying one input byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface acc_in_if;
    logic                           valid;
    logic                           ready;
    logic [acc_pkg::ACC_CHAR_W-1:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

`default_nettype wire

// ----- sv/acc_out_if.sv -----
// ----------------------------------------------------------------------------
// Output character channel
// Valid/ready channel carrying one cipher byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface acc_out_if;
    logic                           valid;
    logic                           ready;
    logic [acc_pkg::ACC_CHAR_W-1:0] char_out;

    modport source (output valid, output char_out, input ready);
    modport sink   (input valid, input char_out, output ready);
endinterface

`default_nettype wire

// ----- sv/acc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface acc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [acc_pkg::ACC_IDX_W-1:0] index;
    logic [acc_pkg::ACC_KEY_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/acc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// Holds modulus, multiplier, offset and mode; presents the effective modulus.
// ----------------------------------------------------------------------------
`default_nettype none

module acc_cfg_regs (
    input  wire              i_clk,
    input  wire              i_rst_n,
    acc_cfg_if.sink          i_cfg,
    output acc_pkg::t_cfg    o_cfg
);

    logic [acc_pkg::ACC_KEY_W-1:0] r_modulus;
    logic [acc_pkg::ACC_KEY_W-1:0] r_multiplier;
    logic [acc_pkg::ACC_KEY_W-1:0] r_offset;
    logic                          r_decrypt;

    // Always take writes
    assign i_cfg.ready = 1'b1;

    // Update the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus    <= acc_pkg::RST_MODULUS;
            r_multiplier <= acc_pkg::RST_MULTIPLIER;
            r_offset     <= acc_pkg::RST_OFFSET;
            r_decrypt    <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                acc_pkg::CFG_MODULUS:    r_modulus    <= i_cfg.data;
                acc_pkg::CFG_MULTIPLIER: r_multiplier <= i_cfg.data;
                acc_pkg::CFG_OFFSET:     r_offset     <= i_cfg.data;
                acc_pkg::CFG_DECRYPT:    r_decrypt    <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    // Treat a zero modulus as one
    always_comb begin
        o_cfg.m       = (r_modulus == '0) ? acc_pkg::ACC_KEY_W'(1) : r_modulus;
        o_cfg.mult    = r_multiplier;
        o_cfg.offset  = r_offset;
        o_cfg.decrypt = r_decrypt;
    end

endmodule

`default_nettype wire

// ----- sv/acc_front.sv -----
// ----------------------------------------------------------------------------
// Cipher front end
// Two stages: decode the byte into an index and operands, then multiply-add.
// Encrypt forms mult*p + offset; decrypt forms mult*(p + 128*m - offset),
// both congruent to the cipher value mod m.
// ----------------------------------------------------------------------------
`default_nettype none

module acc_front (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  acc_pkg::t_cfg                    i_cfg,
    input  wire                              i_vld,
    input  wire [acc_pkg::ACC_CHAR_W-1:0]    i_char,
    output logic                             o_vld,
    output logic [acc_pkg::ACC_PROD_W-1:0]   o_prod
);

    logic [acc_pkg::ACC_CHAR_W-1:0] w_c1;
    logic [acc_pkg::ACC_CHAR_W-1:0] w_c2;
    logic                           w_letter;
    logic                           w_space;
    logic [acc_pkg::ACC_KEY_W-1:0]  w_p;
    logic [acc_pkg::ACC_SUM_W-1:0]  n_s;
    logic [acc_pkg::ACC_KEY_W-1:0]  n_t;

    logic                           r_a_vld;
    logic [acc_pkg::ACC_SUM_W-1:0]  r_s;
    logic [acc_pkg::ACC_KEY_W-1:0]  r_t;
    logic                           r_b_vld;
    logic [acc_pkg::ACC_PROD_W-1:0] r_prod;
    logic [acc_pkg::ACC_PROD_W-1:0] n_prod;

    // Decode: newline to space, fold case, map to an index
    always_comb begin
        w_c1 = (i_char == acc_pkg::CH_NEWLINE) ? acc_pkg::CH_SPACE : i_char;
        w_c2 = w_c1;
        if (w_c1 >= acc_pkg::CH_UPPER_A && w_c1 <= acc_pkg::CH_UPPER_Z) begin
            w_c2 = w_c1 + acc_pkg::CH_CASE_GAP;
        end
        w_letter = (w_c2 >= acc_pkg::CH_LOWER_A) && (w_c2 <= acc_pkg::CH_LOWER_Z);
        w_space  = (w_c2 == acc_pkg::CH_SPACE);
        w_p      = w_letter ? acc_pkg::ACC_KEY_W'(w_c2 - acc_pkg::CH_LOWER_A)
                            : i_cfg.m - acc_pkg::ACC_KEY_W'(1);
        if (i_cfg.decrypt) begin
            // Adding 128*m keeps the difference non-negative
            n_s = acc_pkg::ACC_SUM_W'(w_p) + {i_cfg.m, acc_pkg::ACC_KEY_W'(0)}
                - acc_pkg::ACC_SUM_W'(i_cfg.offset);
            n_t = '0;
        end else begin
            n_s = acc_pkg::ACC_SUM_W'(w_p);
            n_t = i_cfg.offset;
        end
    end

    // Multiply-add on the registered operands
    assign n_prod = acc_pkg::ACC_PROD_W'(r_s) * acc_pkg::ACC_PROD_W'(i_cfg.mult)
                  + acc_pkg::ACC_PROD_W'(r_t);

    // Advance valid bits; drop bytes outside the alphabet here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld && (w_letter || w_space);
            r_b_vld <= r_a_vld;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s    <= n_s;
            r_t    <= n_t;
            r_prod <= n_prod;
        end
    end

    assign o_vld  = r_b_vld;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ----- sv/acc_mod_step.sv -----
// ----------------------------------------------------------------------------
// Modulo reduction stage
// Runs NBITS restoring long-division steps on the dividend bits from HI down,
// then registers the partial remainder together with the dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module acc_mod_step #(
    parameter int HI    = acc_pkg::ACC_PROD_W - 1,
    parameter int NBITS = acc_pkg::ACC_STEPS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  acc_pkg::t_cfg                    i_cfg,
    input  wire                              i_vld,
    input  wire [acc_pkg::ACC_PROD_W-1:0]    i_val,
    input  wire [acc_pkg::ACC_KEY_W-1:0]     i_rem,
    output logic                             o_vld,
    output logic [acc_pkg::ACC_PROD_W-1:0]   o_val,
    output logic [acc_pkg::ACC_KEY_W-1:0]    o_rem
);

    logic [acc_pkg::ACC_KEY_W:0]   w_t;
    logic [acc_pkg::ACC_KEY_W-1:0] n_rem;
    logic                          r_vld;
    logic [acc_pkg::ACC_PROD_W-1:0] r_val;
    logic [acc_pkg::ACC_KEY_W-1:0] r_rem;

    // Shift in one dividend bit per step, subtract m when it fits
    always_comb begin
        n_rem = i_rem;
        w_t   = '0;
        for (int i = 0; i < NBITS; i++) begin
            w_t = {n_rem, i_val[HI - i]};
            if (w_t >= {1'b0, i_cfg.m}) begin
                w_t = w_t - {1'b0, i_cfg.m};
            end
            n_rem = w_t[acc_pkg::ACC_KEY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= i_val;
            r_rem <= n_rem;
        end
    end

    assign o_vld = r_vld;
    assign o_val = r_val;
    assign o_rem = r_rem;

endmodule

`default_nettype wire

// ----- sv/affine_char_cipher.sv -----
// ----------------------------------------------------------------------------
// Affine character cipher
// Streams bytes through an affine cipher over a configurable alphabet.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : one ASCII byte per item. Letters, space and newline give one
//            result; any other byte is consumed and gives none.
//   o_out  : one cipher byte per result: space for residue m-1, else 97+v.
//   i_cfg  : register writes (0 modulus, 1 multiplier, 2 offset, 3 mode),
//            always ready; write only while no items are in flight.
// Throughput: one item per cycle while o_out takes its items.
// Pipeline: two front stages (decode, multiply-add), the long-division
//   stages of the mod-m reduction and the output register lie between
//   accept and o_out.valid.
// Stall: when o_out holds an item that is not taken, the whole pipeline
//   freezes and i_in.ready drops; nothing is lost or repeated.
// Reset: clears every valid bit and loads modulus 27, multiplier 1,
//   offset 0, encrypt mode.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_char_cipher #(
    parameter int STEPS_PER_STAGE = acc_pkg::ACC_STEPS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    acc_in_if.sink      i_in,
    acc_out_if.source   o_out,
    acc_cfg_if.sink     i_cfg
);

    localparam int NUM_STAGES = (acc_pkg::ACC_PROD_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    acc_pkg::t_cfg                  w_cfg;
    logic                           w_en;
    logic                           w_vld [0:NUM_STAGES];
    logic [acc_pkg::ACC_PROD_W-1:0] w_val [0:NUM_STAGES];
    logic [acc_pkg::ACC_KEY_W-1:0]  w_rem [0:NUM_STAGES];
    logic [acc_pkg::ACC_CHAR_W-1:0] n_char_out;
    logic                           r_out_vld;
    logic [acc_pkg::ACC_CHAR_W-1:0] r_char_out;

    acc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // Advance the pipeline unless the output holds an untaken item
    assign w_en       = !r_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    acc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (w_cfg),
        .i_vld   (i_in.valid),
        .i_char  (i_in.char_in),
        .o_vld   (w_vld[0]),
        .o_prod  (w_val[0])
    );

    assign w_rem[0] = '0;

    // Reduction stages, MSB first
    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_mod
        localparam int HI = acc_pkg::ACC_PROD_W - 1 - k * STEPS_PER_STAGE;
        localparam int NB = (HI + 1 < STEPS_PER_STAGE) ? HI + 1 : STEPS_PER_STAGE;

        acc_mod_step #(
            .HI    (HI),
            .NBITS (NB)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cfg   (w_cfg),
            .i_vld   (w_vld[k]),
            .i_val   (w_val[k]),
            .i_rem   (w_rem[k]),
            .o_vld   (w_vld[k+1]),
            .o_val   (w_val[k+1]),
            .o_rem   (w_rem[k+1])
        );
    end

    // Map the residue back to a character
    assign n_char_out = (w_rem[NUM_STAGES] == w_cfg.m - acc_pkg::ACC_KEY_W'(1))
                      ? acc_pkg::CH_SPACE
                      : acc_pkg::CH_LOWER_A + acc_pkg::ACC_CHAR_W'(w_rem[NUM_STAGES]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_vld[NUM_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_char_out <= n_char_out;
        end
    end

    assign o_out.valid    = r_out_vld;
    assign o_out.char_out = r_char_out;

    // The final remainder is fully reduced
    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[NUM_STAGES] |-> (w_rem[NUM_STAGES] < w_cfg.m))
        else $error("remainder not below modulus");

    // A result is a space or a letter below residue m-1
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.char_out == acc_pkg::CH_SPACE) ||
            ((o_out.char_out >= acc_pkg::CH_LOWER_A) &&
             ((o_out.char_out - acc_pkg::CH_LOWER_A) <
              (acc_pkg::ACC_CHAR_W'(w_cfg.m) - acc_pkg::ACC_CHAR_W'(1)))))
        else $error("output character out of range");

    // A stall freezes the pipeline valid bits
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_vld[0]) && $stable(w_vld[NUM_STAGES]))
        else $error("pipeline moved during stall");

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Affine character cipher testbench
// Drives bytes through the cipher under several key settings and both modes,
// takes each expected cipher byte from a table or predicts it from a local
// copy of the keys, and compares every output item against the oldest pending one.
// ----------------------------------------------------------------------------

module tb_top;

    // Cycles to let dropped bytes leave the pipeline before a key change
    localparam int PIPE_SETTLE = 24;
    localparam int ITEMS_PER_PHASE = 68;
    localparam int NUM_PHASES = 8;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_TYPED,
        ROW_DROPPED,
        ROW_PREDICTED
    } t_row_kind;

    typedef struct packed {
        t_row_kind                      kind;
        logic [acc_pkg::ACC_CHAR_W-1:0] ch;
        logic [acc_pkg::ACC_CHAR_W-1:0] want;
        logic [acc_pkg::ACC_KEY_W-1:0]  modulus;
        logic [acc_pkg::ACC_KEY_W-1:0]  mult;
        logic [acc_pkg::ACC_KEY_W-1:0]  offset;
        logic                           decrypt;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    acc_in_if  in_ch ();
    acc_out_if out_ch ();
    acc_cfg_if cfg_ch ();

    affine_char_cipher uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Local copy of the key registers
    logic [acc_pkg::ACC_KEY_W-1:0] key_modulus;
    logic [acc_pkg::ACC_KEY_W-1:0] key_mult;
    logic [acc_pkg::ACC_KEY_W-1:0] key_offset;
    logic                          key_decrypt;

    logic [acc_pkg::ACC_CHAR_W-1:0] cipher_q[$];
    int mismatch_cnt;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Hard limit on run time
    initial begin
        #5_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Compute the cipher byte for c under the current keys; 0 if c is dropped
    function automatic bit cipher_byte(input logic [acc_pkg::ACC_CHAR_W-1:0] c,
                                       output logic [acc_pkg::ACC_CHAR_W-1:0] res);
        int unsigned m, cc, p, a, b, v;
        m = (key_modulus == 0) ? 1 : key_modulus;
        cc = c;
        res = '0;
        if (cc == acc_pkg::CH_NEWLINE) cc = acc_pkg::CH_SPACE;
        if (cc >= acc_pkg::CH_UPPER_A && cc <= acc_pkg::CH_UPPER_Z)
            cc = cc + acc_pkg::CH_CASE_GAP;
        if (cc >= acc_pkg::CH_LOWER_A && cc <= acc_pkg::CH_LOWER_Z) begin
            p = cc - acc_pkg::CH_LOWER_A;
        end else if (cc == acc_pkg::CH_SPACE) begin
            p = m - 1;
        end else begin
            return 1'b0;
        end
        p = p % m;
        a = key_mult % m;
        b = key_offset % m;
        if (!key_decrypt) begin
            v = (a * p + b) % m;
        end else begin
            v = (((p + m - b) % m) * a) % m;
        end
        if (v == m - 1) res = acc_pkg::CH_SPACE;
        else res = 8'(acc_pkg::CH_LOWER_A + v);
        return 1'b1;
    endfunction

    // Receiver: long hold-off first, then random stalls
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Check each output item against the oldest prediction
    always @(posedge i_clk) begin
        logic [acc_pkg::ACC_CHAR_W-1:0] want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (cipher_q.size() == 0) begin
                mismatch_cnt = mismatch_cnt + 1;
                if (mismatch_cnt <= 10)
                    $display("unexpected cipher byte %0d", out_ch.char_out);
            end else begin
                want = cipher_q.pop_front();
                if (out_ch.char_out !== want) begin
                    mismatch_cnt = mismatch_cnt + 1;
                    if (mismatch_cnt <= 10)
                        $display("cipher byte mismatch: expected %0d got %0d",
                                 want, out_ch.char_out);
                end
            end
        end
    end

    // Offer one byte and queue its expected result once accepted
    task automatic send_char(input logic [acc_pkg::ACC_CHAR_W-1:0] c, input t_row_kind kind,
                             input logic [acc_pkg::ACC_CHAR_W-1:0] want, output bit kept);
        logic [acc_pkg::ACC_CHAR_W-1:0] res;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.char_in <= c;
        do @(posedge i_clk); while (!in_ch.ready);
        kept = cipher_byte(c, res);
        if (kind == ROW_TYPED) cipher_q.push_back(want);
        else if (kind == ROW_PREDICTED && kept) cipher_q.push_back(res);
        @(negedge i_clk);
    endtask

    // Stop offering and wait for every pending result, then settle
    task automatic drain(input int settle);
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (cipher_q.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [acc_pkg::ACC_IDX_W-1:0] idx,
                             input logic [acc_pkg::ACC_KEY_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            acc_pkg::CFG_MODULUS:    key_modulus = val;
            acc_pkg::CFG_MULTIPLIER: key_mult    = val;
            acc_pkg::CFG_OFFSET:     key_offset  = val;
            acc_pkg::CFG_DECRYPT:    key_decrypt = val[0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Load all four key registers; block must be idle
    task automatic load_keys(input logic [acc_pkg::ACC_KEY_W-1:0] modv,
                             input logic [acc_pkg::ACC_KEY_W-1:0] multv,
                             input logic [acc_pkg::ACC_KEY_W-1:0] offv,
                             input logic decv);
        write_reg(acc_pkg::CFG_MODULUS, modv);
        write_reg(acc_pkg::CFG_MULTIPLIER, multv);
        write_reg(acc_pkg::CFG_OFFSET, offv);
        write_reg(acc_pkg::CFG_DECRYPT, {{(acc_pkg::ACC_KEY_W-1){1'b0}}, decv});
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        t_stim_row dir_rows[$];
        t_stim_row row;
        logic [acc_pkg::ACC_CHAR_W-1:0] c;
        logic [acc_pkg::ACC_KEY_W-1:0] modv, multv, offv;
        int kept_cnt;
        int pick;
        bit kept;

        // Hold every input at a known value from time zero
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.char_in  = '0;
        out_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = acc_pkg::CFG_MODULUS;
        cfg_ch.data    = '0;
        mismatch_cnt   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        key_modulus    = acc_pkg::RST_MODULUS;
        key_mult       = acc_pkg::RST_MULTIPLIER;
        key_offset     = acc_pkg::RST_OFFSET;
        key_decrypt    = 1'b0;

        // Reset-default keys: identity over letters, space and newline
        dir_rows.push_back('{ROW_TYPED, "a", "a", 0, 0, 0, 0});
        dir_rows.push_back('{ROW_TYPED, "z", "z", 0, 0, 0, 0});
        dir_rows.push_back('{ROW_TYPED, "A", "a", 0, 0, 0, 0});
        dir_rows.push_back('{ROW_TYPED, "Z", "z", 0, 0, 0, 0});
        dir_rows.push_back('{ROW_TYPED, " ", " ", 0, 0, 0, 0});
        dir_rows.push_back('{ROW_TYPED, acc_pkg::CH_NEWLINE, " ", 0, 0, 0, 0});
        // Bytes just outside the letter ranges, a tab, and the byte extremes
        dir_rows.push_back('{ROW_DROPPED, 8'd0, 8'd0, 0, 0, 0, 0});
        dir_rows.push_back('{ROW_DROPPED, 8'd255, 8'd0, 0, 0, 0, 0});
        dir_rows.push_back('{ROW_DROPPED, 8'd64, 8'd0, 0, 0, 0, 0});
        dir_rows.push_back('{ROW_DROPPED, 8'd91, 8'd0, 0, 0, 0, 0});
        dir_rows.push_back('{ROW_DROPPED, 8'd96, 8'd0, 0, 0, 0, 0});
        dir_rows.push_back('{ROW_DROPPED, 8'd123, 8'd0, 0, 0, 0, 0});
        dir_rows.push_back('{ROW_DROPPED, 8'd9, 8'd0, 0, 0, 0, 0});
        // Zero modulus: every result is a space
        dir_rows.push_back('{ROW_CFG, 8'd0, 8'd0, 7'd0, 7'd1, 7'd0, 1'b0});
        dir_rows.push_back('{ROW_TYPED, "q", " ", 0, 0, 0, 0});
        dir_rows.push_back('{ROW_TYPED, "B", " ", 0, 0, 0, 0});
        // Letter index equal to modulus-1 comes out as a space
        dir_rows.push_back('{ROW_CFG, 8'd0, 8'd0, 7'd26, 7'd1, 7'd0, 1'b0});
        dir_rows.push_back('{ROW_TYPED, "z", " ", 0, 0, 0, 0});
        dir_rows.push_back('{ROW_TYPED, "y", "y", 0, 0, 0, 0});
        // Keys and letters above the modulus
        dir_rows.push_back('{ROW_CFG, 8'd0, 8'd0, 7'd5, 7'd127, 7'd127, 1'b0});
        dir_rows.push_back('{ROW_PREDICTED, "z", 8'd0, 0, 0, 0, 0});
        dir_rows.push_back('{ROW_PREDICTED, "a", 8'd0, 0, 0, 0, 0});
        dir_rows.push_back('{ROW_PREDICTED, "m", 8'd0, 0, 0, 0, 0});
        // Decrypt with a real inverse key
        dir_rows.push_back('{ROW_CFG, 8'd0, 8'd0, 7'd27, 7'd19, 7'd5, 1'b1});
        dir_rows.push_back('{ROW_PREDICTED, "k", 8'd0, 0, 0, 0, 0});
        dir_rows.push_back('{ROW_PREDICTED, " ", 8'd0, 0, 0, 0, 0});
        dir_rows.push_back('{ROW_PREDICTED, "Q", 8'd0, 0, 0, 0, 0});
        // All keys at their maximum, decrypting
        dir_rows.push_back('{ROW_CFG, 8'd0, 8'd0, 7'd127, 7'd127, 7'd127, 1'b1});
        dir_rows.push_back('{ROW_PREDICTED, "z", 8'd0, 0, 0, 0, 0});
        dir_rows.push_back('{ROW_PREDICTED, acc_pkg::CH_NEWLINE, 8'd0, 0, 0, 0, 0});

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG) begin
                drain(PIPE_SETTLE);
                load_keys(row.modulus, row.mult, row.offset, row.decrypt);
            end else begin
                send_char(row.ch, row.kind, row.want, kept);
            end
        end

        // Random phases, each with its own keys and idling pattern
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain(PIPE_SETTLE);
            case (ph)
                0: begin modv = 7'd27;  multv = 7'd0;   offv = 7'd0;   end
                1: begin modv = 7'd2;   multv = 7'($urandom_range(0, 127)); offv = 7'd127; end
                2: begin modv = 7'd64;  multv = 7'd127; offv = 7'($urandom_range(0, 127)); end
                3: begin modv = 7'd127; multv = 7'd127; offv = 7'd127; end
                4: begin modv = 7'd0;   multv = 7'($urandom_range(0, 127)); offv = 7'd5;   end
                5: begin modv = 7'd1;   multv = 7'd3;   offv = 7'd64;  end
                default: begin
                    modv  = 7'($urandom_range(2, 64));
                    multv = 7'($urandom_range(0, 127));
                    offv  = 7'($urandom_range(0, 127));
                end
            endcase
            load_keys(modv, multv, offv, ph[0]);

            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            // Hold off the receiver so the pipeline fills and stalls its input
            if (ph == 0 || ph == 6) hold_cycles = 150;

            kept_cnt = 0;
            while (kept_cnt < ITEMS_PER_PHASE) begin
                // Pause the sender until everything in flight has come out
                if (kept_cnt == ITEMS_PER_PHASE / 2) drain(0);
                pick = $urandom_range(99);
                if (pick < 40) c = acc_pkg::CH_LOWER_A + 8'($urandom_range(0, 25));
                else if (pick < 65) c = acc_pkg::CH_UPPER_A + 8'($urandom_range(0, 25));
                else if (pick < 78) c = acc_pkg::CH_SPACE;
                else if (pick < 83) c = acc_pkg::CH_NEWLINE;
                else c = 8'($urandom_range(0, 255));
                send_char(c, ROW_PREDICTED, 8'd0, kept);
                if (kept) kept_cnt = kept_cnt + 1;
            end
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain(PIPE_SETTLE);

        if (mismatch_cnt == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/acc_pkg.sv
sv/acc_in_if.sv
sv/acc_out_if.sv
sv/acc_cfg_if.sv
sv/acc_cfg_regs.sv
sv/acc_front.sv
sv/acc_mod_step.sv
sv/affine_char_cipher.sv
bench/tb_top.sv
